// ===== sv/smrq_pkg.sv =====
// Package for the source-matched receive queue: widths, codes, state type and result type.
`timescale 1ns / 1ps
`default_nettype none
package smrq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned SRC_W           = 8;
  localparam int unsigned HDL_W           = 16;

  // Function codes of an input word
  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_RECV   = 1'b1;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  // One result word
  typedef struct packed {
    logic             matched;
    logic [HDL_W-1:0] found_handle;
    logic             dropped;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/smrq_if.sv =====
// Valid/ready channel interfaces for request and result words.
`timescale 1ns / 1ps
`default_nettype none
interface smrq_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [smrq_pkg::SRC_W-1:0] source_rank;
  logic [smrq_pkg::HDL_W-1:0] message_handle;

  modport source (output valid, func, source_rank, message_handle, input ready);
  modport sink   (input valid, func, source_rank, message_handle, output ready);
endinterface

interface smrq_out_if;
  logic                       valid;
  logic                       ready;
  logic                       matched;
  logic [smrq_pkg::HDL_W-1:0] found_handle;
  logic                       dropped;

  modport source (output valid, matched, found_handle, dropped, input ready);
  modport sink   (input valid, matched, found_handle, dropped, output ready);
endinterface
`default_nettype wire

// ===== sv/source_matched_receive_queue.sv =====
// Top level: ordered message store with first-match removal by source rank.
`timescale 1ns / 1ps
`default_nettype none
// Messages are kept oldest first in a single-port-write, registered-read
// memory of QUEUE_DEPTH entries. An arrival appends at the tail, or is
// flagged as dropped when the store is full. A receive streams the held
// entries out of the memory one per cycle from the oldest, takes the first
// whose source matches, and writes every later entry one slot down as it
// passes, so the gap closes during the same sweep. A receive on a non-empty
// store enters the sweep, reads and checks each held entry in turn, and
// returns to idle; no new request is taken until it is back in idle. On an
// empty store it gives its result without a sweep. A sweep reads at most
// QUEUE_DEPTH entries, one read per cycle of the memory.
// Every request gives exactly one result word; the next request is taken
// once the controller is idle and the result register is free or draining.
// No clearing pass is needed after reset: only entries below the fill count
// are read.
module source_matched_receive_queue #(
  parameter int unsigned QUEUE_DEPTH = smrq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  smrq_in_if.sink     in_i,
  smrq_out_if.source  out_o
);
  import smrq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = SRC_W + HDL_W;

  // Message store
  logic [EW-1:0] mem_q [QUEUE_DEPTH];
  logic [EW-1:0] rd_data_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    rd_idx_q, rd_idx_d;
  logic [AW-1:0]    chk_idx_q, chk_idx_d;
  logic             chk_vld_q, chk_vld_d;
  logic             hit_q, hit_d;
  logic [HDL_W-1:0] handle_q, handle_d;
  logic [SRC_W-1:0] rank_q, rank_d;

  logic          res_free, res_load;
  result_t       res_data;
  logic          accept;
  logic [CW-1:0] last_idx;
  logic          is_full;

  assign in_i.ready = (state_q == ST_IDLE) && res_free;
  assign accept     = in_i.valid && in_i.ready;
  assign is_full    = (count_q == CW'(QUEUE_DEPTH));
  assign last_idx   = count_q - CW'(1);
  assign rd_addr    = rd_idx_q[AW-1:0];

  // Control and read-modify-write sequencing
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    chk_idx_d = chk_idx_q;
    chk_vld_d = 1'b0;
    hit_d     = hit_q;
    handle_d  = handle_q;
    rank_d    = rank_q;
    wr_en     = 1'b0;
    wr_addr   = count_q[AW-1:0];
    wr_data   = {in_i.source_rank, in_i.message_handle};
    res_load  = 1'b0;
    res_data  = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.func == FUNC_ARRIVE) begin
            res_load = 1'b1;
            if (is_full) begin
              res_data.dropped = 1'b1;
            end else begin
              wr_en   = 1'b1;
              count_d = count_q + CW'(1);
            end
          end else if (count_q == '0) begin
            res_load = 1'b1;
          end else begin
            state_d  = ST_SCAN;
            rd_idx_d = '0;
            hit_d    = 1'b0;
            handle_d = '0;
            rank_d   = in_i.source_rank;
          end
        end
      end
      ST_SCAN: begin
        // Issue the next read while entries remain
        if (rd_idx_q < count_q) begin
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q[AW-1:0];
          rd_idx_d  = rd_idx_q + CW'(1);
        end
        // Check the entry that came back, or move it down after a hit
        if (chk_vld_q) begin
          if (hit_q) begin
            wr_en   = 1'b1;
            wr_addr = chk_idx_q - AW'(1);
            wr_data = rd_data_q;
          end else if (rd_data_q[EW-1:HDL_W] == rank_q) begin
            hit_d    = 1'b1;
            handle_d = rd_data_q[HDL_W-1:0];
          end
          if (chk_idx_q == last_idx[AW-1:0]) begin
            state_d               = ST_IDLE;
            chk_vld_d             = 1'b0;
            res_load              = 1'b1;
            res_data.matched      = hit_d;
            res_data.found_handle = handle_d;
            if (hit_d) begin
              count_d = count_q - CW'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    chk_idx_q <= chk_idx_d;
    hit_q     <= hit_d;
    handle_q  <= handle_d;
    rank_q    <= rank_d;
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  smrq_result_reg u_result (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_load),
    .data_i (res_data),
    .free_o (res_free),
    .out_o  (out_o)
  );
endmodule
`default_nettype wire

// ===== sv/smrq_result_reg.sv =====
// Output register that holds one result word until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none
module smrq_result_reg (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    load_i,
  input  wire smrq_pkg::result_t data_i,
  output logic                   free_o,
  smrq_out_if.source             out_o
);
  import smrq_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  // Register is free when empty or being taken this cycle
  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i ? 1'b1 : (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.matched      = data_q.matched;
  assign out_o.found_handle = data_q.found_handle;
  assign out_o.dropped      = data_q.dropped;
endmodule
`default_nettype wire

// ===== tb/source_matched_receive_queue_tb.sv =====
// Testbench for the source-matched receive queue: directed and random arrivals and receives checked in order.
`timescale 1ns / 1ps
`default_nettype none
module source_matched_receive_queue_tb;
  import smrq_pkg::*;

  localparam int unsigned STORE_DEPTH = QUEUE_DEPTH_DEF;
  localparam int unsigned RANDOM_WORDS = 1900;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned MAX_REPORTS = 50;

  // Random phase kinds
  localparam int PH_FILL  = 0;
  localparam int PH_DRAIN = 1;
  localparam int PH_MIX   = 2;
  localparam int PH_WIDE  = 3;

  // Receiver stall modes
  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_COMB   = 2;
  localparam int RX_STRIKE = 3;

  typedef struct packed {
    logic             func;
    logic [SRC_W-1:0] source_rank;
    logic [HDL_W-1:0] message_handle;
  } req_word_t;

  typedef struct packed {
    logic [SRC_W-1:0] rank;
    logic [HDL_W-1:0] handle;
  } held_msg_t;

  logic clk_i;
  logic rst_ni;

  smrq_in_if  req ();
  smrq_out_if rsp ();

  source_matched_receive_queue #(
    .QUEUE_DEPTH(STORE_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req),
    .out_o (rsp)
  );

  req_word_t pending_words[$];
  result_t   expected_results[$];
  held_msg_t held_msgs[$];
  int unsigned fail_count;
  int unsigned burst_left;
  int unsigned gap_left;
  logic [SRC_W-1:0] rank_pool[4];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch: %s", what);
  endtask

  // Model of the store: apply one word, return the result it gives
  function automatic result_t apply_to_store(input req_word_t w);
    result_t   r;
    held_msg_t m;
    int        hit;
    r   = '0;
    hit = -1;
    if (w.func == FUNC_ARRIVE) begin
      if (held_msgs.size() >= STORE_DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        m.rank   = w.source_rank;
        m.handle = w.message_handle;
        held_msgs.push_back(m);
      end
    end else begin
      // oldest entry with the requested source wins
      foreach (held_msgs[i]) begin
        if (hit < 0 && held_msgs[i].rank == w.source_rank) hit = i;
      end
      if (hit >= 0) begin
        r.matched      = 1'b1;
        r.found_handle = held_msgs[hit].handle;
        held_msgs.delete(hit);
      end
    end
    return r;
  endfunction

  task automatic add_word(input logic func, input logic [SRC_W-1:0] rank,
                          input logic [HDL_W-1:0] handle);
    req_word_t w;
    w.func           = func;
    w.source_rank    = rank;
    w.message_handle = handle;
    pending_words.push_back(w);
  endtask

  function automatic logic [SRC_W-1:0] pick_rank(input int kind);
    if (kind == PH_WIDE || $urandom_range(0, 4) == 0) return SRC_W'($urandom_range(0, 255));
    return rank_pool[$urandom_range(0, 3)];
  endfunction

  // Driver: bursts of words with random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    req_word_t w;
    logic      busy;
    if (!rst_ni) begin
      req.valid          <= 1'b0;
      req.func           <= FUNC_ARRIVE;
      req.source_rank    <= '0;
      req.message_handle <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      busy = req.valid;
      if (req.valid && req.ready) begin
        w = pending_words.pop_front();
        expected_results.push_back(apply_to_store(w));
        busy = 1'b0;
      end
      if (!busy) begin
        if (burst_left != 0 && pending_words.size() != 0) begin
          req.valid          <= 1'b1;
          req.func           <= pending_words[0].func;
          req.source_rank    <= pending_words[0].source_rank;
          req.message_handle <= pending_words[0].message_handle;
          burst_left--;
        end else begin
          req.valid <= 1'b0;
          if (burst_left == 0) begin
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              burst_left = $urandom_range(1, 48);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            end
          end
        end
      end
    end
  end

  // Receiver ready: driven by a stall mode that is redrawn at random on a tick counter
  always @(posedge clk_i or negedge rst_ni) begin
    static int          rx_mode = RX_OPEN;
    static int unsigned rx_tick = 0;
    static int unsigned hold_off = 0;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_tick % 256 == 0) rx_mode = $urandom_range(RX_OPEN, RX_STRIKE);
      case (rx_mode)
        RX_OPEN: begin
          rsp.ready <= 1'b1;
        end
        RX_COIN: begin
          rsp.ready <= ($urandom_range(0, 9) < 7);
        end
        RX_COMB: begin
          rsp.ready <= (rx_tick % 5 != 0);
        end
        default: begin
          if (hold_off != 0) begin
            hold_off--;
            rsp.ready <= 1'b0;
          end else begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) hold_off = $urandom_range(1, 24);
          end
        end
      endcase
    end
  end

  // Monitor: each result against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with no expectation waiting");
      end else begin
        want = expected_results.pop_front();
        if (rsp.matched !== want.matched)
          report_mismatch($sformatf("matched %b, want %b", rsp.matched, want.matched));
        if (rsp.found_handle !== want.found_handle)
          report_mismatch($sformatf("found_handle %h, want %h",
                                    rsp.found_handle, want.found_handle));
        if (rsp.dropped !== want.dropped)
          report_mismatch($sformatf("dropped %b, want %b", rsp.dropped, want.dropped));
      end
    end
  end

  // Watchdog on cycles without any accepted word
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("FAIL source_matched_receive_queue");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned issued;
    int          kind;
    int          span;
    int          recv_pct;
    fail_count         = 0;
    rst_ni             = 1'b0;
    req.valid          = 1'b0;
    req.func           = FUNC_ARRIVE;
    req.source_rank    = '0;
    req.message_handle = '0;
    rsp.ready          = 1'b0;

    // receives on an empty store
    add_word(FUNC_RECV, 8'h00, 16'hFFFF);
    add_word(FUNC_RECV, 8'hFF, 16'h0000);
    // extremes, two messages from one source
    add_word(FUNC_ARRIVE, 8'h00, 16'h0000);
    add_word(FUNC_ARRIVE, 8'hFF, 16'hFFFF);
    add_word(FUNC_ARRIVE, 8'h00, 16'h1234);
    add_word(FUNC_ARRIVE, 8'hAA, 16'h5555);
    add_word(FUNC_ARRIVE, 8'h55, 16'hAAAA);
    // oldest of a source first, then a miss on that source
    add_word(FUNC_RECV, 8'h00, 16'hBEEF);
    add_word(FUNC_RECV, 8'h00, 16'h0000);
    add_word(FUNC_RECV, 8'h00, 16'hFFFF);
    // tail, head, last entry
    add_word(FUNC_RECV, 8'h55, 16'h0000);
    add_word(FUNC_RECV, 8'hFF, 16'h0000);
    add_word(FUNC_RECV, 8'hAA, 16'h0000);
    // removal from the middle must keep the order of the rest
    add_word(FUNC_ARRIVE, 8'h01, 16'h0101);
    add_word(FUNC_ARRIVE, 8'h02, 16'h0202);
    add_word(FUNC_ARRIVE, 8'h03, 16'h0303);
    add_word(FUNC_ARRIVE, 8'h02, 16'h0222);
    add_word(FUNC_RECV, 8'h02, 16'h0000);
    add_word(FUNC_RECV, 8'h03, 16'h0000);
    add_word(FUNC_RECV, 8'h02, 16'h0000);
    add_word(FUNC_RECV, 8'h01, 16'h0000);
    add_word(FUNC_RECV, 8'h01, 16'h0000);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sender holds off until every directed result is back
    while (pending_words.size() != 0 || expected_results.size() != 0) @(negedge clk_i);

    // overfill the store so arrivals get dropped
    rank_pool[0] = 8'h00;
    rank_pool[1] = 8'hFF;
    rank_pool[2] = 8'h5A;
    rank_pool[3] = 8'hA5;
    for (int i = 0; i < STORE_DEPTH + 6; i++)
      add_word(FUNC_ARRIVE, pick_rank(PH_FILL), HDL_W'($urandom));
    issued = STORE_DEPTH + 6;

    // random phases over a small pool of sources so receives match often
    while (issued < RANDOM_WORDS) begin
      kind = $urandom_range(PH_FILL, PH_WIDE);
      span = $urandom_range(40, 120);
      for (int i = 0; i < 4; i++) rank_pool[i] = SRC_W'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 0) rank_pool[0] = 8'h00;
      if ($urandom_range(0, 1) == 0) rank_pool[1] = 8'hFF;
      case (kind)
        PH_FILL:  recv_pct = 10;
        PH_DRAIN: recv_pct = 85;
        default:  recv_pct = 50;
      endcase
      for (int i = 0; i < span; i++) begin
        if ($urandom_range(0, 99) < recv_pct)
          add_word(FUNC_RECV, pick_rank(kind), HDL_W'($urandom));
        else
          add_word(FUNC_ARRIVE, pick_rank(kind), HDL_W'($urandom));
      end
      issued += span;
    end

    while (pending_words.size() != 0 || expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS source_matched_receive_queue");
    end else begin
      $display("FAIL source_matched_receive_queue");
    end
    $finish;
  end

endmodule
`default_nettype wire
